>>> rtl/dcr_pkg.sv
// Package for the deframer with repeat collapsing.
// Holds the character codes, register indexes and the queue record type.
// Used by dcr_front, dcr_queue, dcr_back and deframe_collapse_repeats.
`default_nettype none

package dcr_pkg;

  // Width of the frame length counters and of the length field.
  localparam int unsigned LEN_W = 24;

  // Queue between the front and the back.
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = 2;

  // Framing characters.
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO      = 8'h30;

  // Register indexes on the configuration port.
  localparam logic CFG_FRAMING_MODE = 1'b0;
  localparam logic CFG_MAX_LENGTH   = 1'b1;

  // Framing modes.
  localparam logic MODE_ESCAPE = 1'b0;
  localparam logic MODE_LENGTH = 1'b1;

  // Reset value of the frame length limit (10 MiB).
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 24'd10485760;

  // One classified input byte: one result, or two when two is set.
  typedef struct packed {
    logic [7:0]       b0;
    logic [7:0]       b1;
    logic             two;
    logic             valid;
    logic             fend;
    logic             perr;
    logic [LEN_W-1:0] len;
  } dcr_rec_t;

endpackage

`default_nettype wire

>>> rtl/deframe_collapse_repeats.sv
// Top level of the deframer with repeat collapsing.
// Instantiates dcr_front, dcr_queue and dcr_back; depends on dcr_pkg.
//
//   Channel  Signals                                   Direction
//   in       in_valid, in_stall, in_data_byte          byte in
//   out      out_valid, out_stall, out_byte, ...       result out
//   cfg      cfg_we, cfg_index, cfg_data               register write
//
// One input byte is accepted per cycle while the four-entry queue has room.
// Results leave at one per cycle from the output register while out_stall is
// low, so a byte that yields an escape pair gives two output transactions; the back end sets the rate.
// Reset is synchronous and active low; no clearing pass.
// A stalled output fills the queue, after which in_stall is raised.
`default_nettype none

module deframe_collapse_repeats (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic                      cfg_index,
  input  wire logic [dcr_pkg::LEN_W-1:0] cfg_data,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [7:0]                in_data_byte,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [7:0]                     out_byte,
  output logic                           out_byte_valid,
  output logic                           out_frame_end,
  output logic [dcr_pkg::LEN_W-1:0]      out_frame_length,
  output logic                           out_protocol_error,
  output logic                           out_last_of_input
);

  logic              in_accept;
  logic              push, pop, q_full, q_empty;
  dcr_pkg::dcr_rec_t wr_rec, rd_rec;

  // Input transactions are taken while the queue has room.
  assign in_stall  = q_full;
  assign in_accept = in_valid && !q_full;

  dcr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_accept    (in_accept),
    .in_data_byte (in_data_byte),
    .push         (push),
    .rec          (wr_rec)
  );

  dcr_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_rec (wr_rec),
    .pop    (pop),
    .rd_rec (rd_rec),
    .full   (q_full),
    .empty  (q_empty)
  );

  dcr_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .rec                (rd_rec),
    .q_empty            (q_empty),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte           (out_byte),
    .out_byte_valid     (out_byte_valid),
    .out_frame_end      (out_frame_end),
    .out_frame_length   (out_frame_length),
    .out_protocol_error (out_protocol_error),
    .out_last_of_input  (out_last_of_input)
  );

endmodule

`default_nettype wire

>>> rtl/dcr_front.sv
// Front end of the deframer: accepts bytes, runs the framing state and
// classifies each byte into a queue record. Depends on dcr_pkg.
`default_nettype none

module dcr_front (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic                     cfg_index,
  input  wire logic [dcr_pkg::LEN_W-1:0] cfg_data,
  input  wire logic                     in_accept,
  input  wire logic [7:0]               in_data_byte,
  output logic                          push,
  output dcr_pkg::dcr_rec_t             rec
);

  // Largest length that the length field can hold.
  localparam logic [32:0] LEN_MASK = (33'd1 << dcr_pkg::LEN_W) - 33'd1;

  // Configuration registers.
  logic                      mode_r;
  logic [dcr_pkg::LEN_W-1:0] max_r;

  // Framing state.
  logic                      esc_r, esc_nxt;
  logic                      have_r, have_nxt;
  logic [7:0]                prev_r, prev_nxt;
  logic [2:0]                hcnt_r, hcnt_nxt;
  logic [31:0]               hshift_r, hshift_nxt;
  logic [dcr_pkg::LEN_W-1:0] remain_r, remain_nxt;
  logic [dcr_pkg::LEN_W-1:0] written_r, written_nxt;
  logic                      err_r, err_nxt;

  // Per-byte working values.
  logic [1:0]                n;
  logic [7:0]                e0, e1;
  logic                      fend, perr, setprev;
  logic [2:0]                cnt;
  logic [31:0]               shift;
  logic [dcr_pkg::LEN_W-1:0] limit;
  logic [dcr_pkg::LEN_W:0]   sum;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= dcr_pkg::MODE_ESCAPE;
      max_r  <= dcr_pkg::MAX_LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dcr_pkg::CFG_FRAMING_MODE: mode_r <= cfg_data[0];
        dcr_pkg::CFG_MAX_LENGTH:   max_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective limit is the smaller of the register and the length range.
  assign limit = ({8'b0, max_r} > LEN_MASK[31:0]) ? LEN_MASK[dcr_pkg::LEN_W-1:0] : max_r;

  // Classification of one byte and the next framing state.
  always_comb begin
    esc_nxt     = esc_r;
    have_nxt    = have_r;
    prev_nxt    = prev_r;
    hcnt_nxt    = hcnt_r;
    hshift_nxt  = hshift_r;
    remain_nxt  = remain_r;
    written_nxt = written_r;
    err_nxt     = err_r;
    push        = 1'b0;
    rec         = '0;
    n           = 2'd0;
    e0          = 8'd0;
    e1          = 8'd0;
    fend        = 1'b0;
    perr        = 1'b0;
    setprev     = 1'b0;
    cnt         = hcnt_r;
    shift       = hshift_r;
    sum         = {1'b0, written_r};
    if (in_accept) begin
      if (err_r) begin
        push     = 1'b1;
        rec.perr = 1'b1;
        rec.len  = written_r;
      end else begin
        if (mode_r == dcr_pkg::MODE_ESCAPE) begin
          // Escape mode: a backslash opens a two-byte escape.
          if (esc_r) begin
            esc_nxt = 1'b0;
            if (in_data_byte == dcr_pkg::CH_BACKSLASH) begin
              if (!have_r || prev_r != dcr_pkg::CH_BACKSLASH) begin
                n       = 2'd2;
                e0      = dcr_pkg::CH_BACKSLASH;
                e1      = dcr_pkg::CH_BACKSLASH;
                setprev = 1'b1;
              end
            end else if (in_data_byte == dcr_pkg::CH_ZERO) begin
              n    = 2'd2;
              e0   = dcr_pkg::CH_BACKSLASH;
              e1   = dcr_pkg::CH_ZERO;
              fend = 1'b1;
            end else begin
              perr = 1'b1;
            end
          end else if (in_data_byte == dcr_pkg::CH_BACKSLASH) begin
            esc_nxt = 1'b1;
          end else if (!have_r || prev_r != in_data_byte) begin
            n       = 2'd1;
            e0      = in_data_byte;
            setprev = 1'b1;
          end
        end else begin
          // Length mode: a spent payload restarts header collection.
          if (hcnt_r >= 3'd4 && remain_r == '0) begin
            cnt   = 3'd0;
            shift = 32'd0;
          end
          if (cnt < 3'd4) begin
            shift      = {shift[23:0], in_data_byte};
            cnt        = cnt + 3'd1;
            hcnt_nxt   = cnt;
            hshift_nxt = shift;
            if (cnt == 3'd4) begin
              if (shift > {8'b0, max_r} || shift > LEN_MASK[31:0]) begin
                perr = 1'b1;
              end else begin
                remain_nxt = shift[dcr_pkg::LEN_W-1:0];
                fend       = (shift == 32'd0);
              end
            end
          end else begin
            if (!have_r || prev_r != in_data_byte) begin
              n       = 2'd1;
              e0      = in_data_byte;
              setprev = 1'b1;
            end
            remain_nxt = remain_r - 1'b1;
            fend       = (remain_r == {{(dcr_pkg::LEN_W-1){1'b0}}, 1'b1});
          end
        end

        // Overflow of the written count.
        sum = {1'b0, written_r} + {{(dcr_pkg::LEN_W-1){1'b0}}, n};
        if (!perr && sum > {1'b0, limit}) begin
          perr = 1'b1;
        end

        if (perr) begin
          err_nxt  = 1'b1;
          push     = 1'b1;
          rec.perr = 1'b1;
          rec.len  = written_r;
        end else begin
          if (setprev) begin
            prev_nxt = (n == 2'd2) ? e1 : e0;
            have_nxt = 1'b1;
          end
          written_nxt = sum[dcr_pkg::LEN_W-1:0];
          push        = (n != 2'd0) || fend;
          rec.b0      = e0;
          rec.b1      = e1;
          rec.two     = (n == 2'd2);
          rec.valid   = (n != 2'd0);
          rec.fend    = fend;
          rec.len     = (n != 2'd0) ? written_r + 1'b1 : written_r;
          if (fend) begin
            written_nxt = '0;
            if (mode_r == dcr_pkg::MODE_ESCAPE) begin
              if (!have_r) begin
                prev_nxt = dcr_pkg::CH_ZERO;
                have_nxt = 1'b1;
              end
            end else begin
              hcnt_nxt   = 3'd0;
              hshift_nxt = 32'd0;
            end
          end
        end
      end
    end
  end

  // Framing state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r     <= 1'b0;
      have_r    <= 1'b0;
      prev_r    <= 8'd0;
      hcnt_r    <= 3'd0;
      hshift_r  <= 32'd0;
      remain_r  <= '0;
      written_r <= '0;
      err_r     <= 1'b0;
    end else begin
      esc_r     <= esc_nxt;
      have_r    <= have_nxt;
      prev_r    <= prev_nxt;
      hcnt_r    <= hcnt_nxt;
      hshift_r  <= hshift_nxt;
      remain_r  <= remain_nxt;
      written_r <= written_nxt;
      err_r     <= err_nxt;
    end
  end

`ifndef ASSERT_OFF
  // Once an error is seen it stays until reset.
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |=> err_r)
    else $error("protocol error flag cleared without reset");

  // The written count never passes the effective limit.
  a_written_limit: assert property (@(posedge clk) disable iff (!rst_n)
    !err_r && !in_accept |=> written_r <= limit || err_r)
    else $error("frame length count above limit");
`endif

endmodule

`default_nettype wire

>>> rtl/dcr_queue.sv
// Short record queue between the front end and the back end.
// Depends on dcr_pkg for the record type and depth.
`default_nettype none

module dcr_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  dcr_pkg::dcr_rec_t      wr_rec,
  input  wire logic              pop,
  output dcr_pkg::dcr_rec_t      rd_rec,
  output logic                   full,
  output logic                   empty
);

  dcr_pkg::dcr_rec_t             mem [dcr_pkg::Q_DEPTH];
  logic [dcr_pkg::Q_AW-1:0]      wptr_r, rptr_r;
  logic [dcr_pkg::Q_AW:0]        count_r;

  assign full   = (count_r == dcr_pkg::Q_DEPTH[dcr_pkg::Q_AW:0]);
  assign empty  = (count_r == '0);
  assign rd_rec = mem[rptr_r];

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= wr_rec;
    end
  end

  // Pointers and fill count; the count holds when both or neither move.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  // Neither overrun nor underrun.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full) && !(pop && empty))
    else $error("queue overrun or underrun");
`endif

endmodule

`default_nettype wire

>>> rtl/dcr_back.sv
// Back end of the deframer: expands queue records into result transactions
// through an output register. Depends on dcr_pkg.
`default_nettype none

module dcr_back (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  dcr_pkg::dcr_rec_t              rec,
  input  wire logic                      q_empty,
  output logic                           pop,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [7:0]                     out_byte,
  output logic                           out_byte_valid,
  output logic                           out_frame_end,
  output logic [dcr_pkg::LEN_W-1:0]      out_frame_length,
  output logic                           out_protocol_error,
  output logic                           out_last_of_input
);

  logic                      valid_r;
  logic                      half_r, half_nxt;
  logic                      load;
  logic [7:0]                byte_r;
  logic                      bval_r, fend_r, perr_r, last_r;
  logic [dcr_pkg::LEN_W-1:0] len_r;

  // A new result is loaded when the output register is free or being taken.
  assign load = !q_empty && (!valid_r || !out_stall);
  assign pop  = load && (half_r || !rec.two);

  always_comb begin
    half_nxt = half_r;
    if (load) begin
      half_nxt = rec.two && !half_r;
    end
  end

  // Output register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      half_r  <= 1'b0;
    end else begin
      half_r <= half_nxt;
      if (load) begin
        valid_r <= 1'b1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  // Output register payload: first or second result of the record.
  always_ff @(posedge clk) begin
    if (load) begin
      if (half_r) begin
        byte_r <= rec.b1;
        bval_r <= 1'b1;
        fend_r <= rec.fend;
        perr_r <= 1'b0;
        len_r  <= rec.len + 1'b1;
        last_r <= 1'b1;
      end else begin
        byte_r <= rec.b0;
        bval_r <= rec.valid;
        fend_r <= rec.fend && !rec.two;
        perr_r <= rec.perr;
        len_r  <= rec.len;
        last_r <= !rec.two;
      end
    end
  end

  assign out_valid          = valid_r;
  assign out_byte           = byte_r;
  assign out_byte_valid     = bval_r;
  assign out_frame_end      = fend_r;
  assign out_frame_length   = len_r;
  assign out_protocol_error = perr_r;
  assign out_last_of_input  = last_r;

`ifndef ASSERT_OFF
  // While the second half is pending its record stays at the queue head.
  a_half_holds: assert property (@(posedge clk) disable iff (!rst_n)
    half_r |-> !q_empty && rec.two)
    else $error("second result pending without a two-result record");
`endif

endmodule

`default_nettype wire
